// ===== design/rgbc_pkg.sv =====
// shared constants, types and codes for the rgbc colour normaliser and classifier
// no dependencies; every module of the block imports this package
package rgbc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RAW_W       = 16;
	localparam int LEVEL_W     = 8;
	localparam int DEN_W       = RAW_W;
	localparam int NUM_W       = DEN_W + LEVEL_W;
	localparam int STEPS       = LEVEL_W;
	localparam int LANES       = 3;
	localparam int CLASS_W     = 3;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((33'd1 << SAMPLE_BITS) - 33'd1);
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = '1;
	localparam logic [LEVEL_W-1:0] ZERO_LEVEL = '0;

	// colour class codes
	localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_RED    = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_BLUE   = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd4;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_DOMINANT = 2'd0;
	localparam logic [1:0] REG_ABSENT   = 2'd1;
	localparam logic [1:0] REG_MIXED    = 2'd2;

	localparam logic [LEVEL_W-1:0] DOMINANT_RST = 8'd200;
	localparam logic [LEVEL_W-1:0] ABSENT_RST   = 8'd80;
	localparam logic [LEVEL_W-1:0] MIXED_RST    = 8'd150;

	typedef struct packed {
		logic [LEVEL_W-1:0] dominant;
		logic [LEVEL_W-1:0] absent;
		logic [LEVEL_W-1:0] mixed;
	} thr_t;

endpackage

// ===== design/rgbc_regs.sv =====
// apb threshold registers of the rgbc block
// depends on rgbc_pkg for register indexes, reset values and thr_t
module rgbc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rgbc_pkg::ADDR_W-1:0] paddr,
	input  logic [rgbc_pkg::DATA_W-1:0] pwdata,
	output logic [rgbc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rgbc_pkg::thr_t              thr
);
	import rgbc_pkg::*;

	thr_t       thr_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.dominant <= DOMINANT_RST;
			thr_q.absent   <= ABSENT_RST;
			thr_q.mixed    <= MIXED_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DOMINANT: thr_q.dominant <= pwdata[LEVEL_W-1:0];
				REG_ABSENT:   thr_q.absent   <= pwdata[LEVEL_W-1:0];
				REG_MIXED:    thr_q.mixed    <= pwdata[LEVEL_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DOMINANT: prdata = DATA_W'(thr_q.dominant);
			REG_ABSENT:   prdata = DATA_W'(thr_q.absent);
			REG_MIXED:    prdata = DATA_W'(thr_q.mixed);
			default:      prdata = '0;
		endcase
	end

	assign thr = thr_q;

endmodule

// ===== design/rgbc_div_lane.sv =====
// one divider lane: pipelined restoring division, one quotient bit per stage
// quotient saturates at full level; depends on rgbc_pkg for widths
module rgbc_div_lane (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rgbc_pkg::NUM_W-1:0]   num,
	input  logic [rgbc_pkg::DEN_W-1:0]   den,
	output logic [rgbc_pkg::LEVEL_W-1:0] quo
);
	import rgbc_pkg::*;

	logic [DEN_W-1:0]   rem_s [0:STEPS-1];
	logic [LEVEL_W-1:0] low_s [0:STEPS-1];
	logic [DEN_W-1:0]   den_s [0:STEPS-1];
	logic [LEVEL_W-1:0] quo_s [0:STEPS];
	logic               sat_s [0:STEPS];
	logic [DEN_W:0]     trial [1:STEPS];
	logic               fit   [1:STEPS];

	// quotient too big for the level width when the top part alone reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num[NUM_W-1 -: DEN_W];
			low_s[0] <= num[LEVEL_W-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			sat_s[0] <= (num[NUM_W-1 -: DEN_W] >= den);
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		assign trial[k] = {rem_s[k-1], low_s[k-1][LEVEL_W-1]};
		assign fit[k]   = (trial[k] >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_s[k-1][LEVEL_W-2:0], fit[k]};
				sat_s[k] <= sat_s[k-1];
			end
		end

		if (k < STEPS) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fit[k] ? DEN_W'(trial[k] - {1'b0, den_s[k-1]})
					                   : trial[k][DEN_W-1:0];
					low_s[k] <= {low_s[k-1][LEVEL_W-2:0], 1'b0};
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = sat_s[STEPS] ? FULL_LEVEL : quo_s[STEPS];

endmodule

// ===== design/rgbc_classify.sv =====
// merging stage: classifies the stretched colour and holds the result item
// depends on rgbc_pkg for class codes, thresholds and widths
module rgbc_classify (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [rgbc_pkg::LEVEL_W-1:0] lvl_r,
	input  logic [rgbc_pkg::LEVEL_W-1:0] lvl_g,
	input  logic [rgbc_pkg::LEVEL_W-1:0] lvl_b,
	input  rgbc_pkg::thr_t               thr,
	output logic                         out_valid,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_red,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_green,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_blue,
	output logic [rgbc_pkg::CLASS_W-1:0] color_class
);
	import rgbc_pkg::*;

	logic               vld_q;
	logic [LEVEL_W-1:0] r_q, g_q, b_q;
	logic [CLASS_W-1:0] cls_q;
	logic [LEVEL_W-1:0] r_n, g_n, b_n;
	logic [CLASS_W-1:0] cls_n;
	logic               r_dom, g_dom, b_dom, r_abs, g_abs, b_abs, r_mix, g_mix;

	assign r_dom = lvl_r >= thr.dominant;
	assign g_dom = lvl_g >= thr.dominant;
	assign b_dom = lvl_b >= thr.dominant;
	assign r_abs = lvl_r < thr.absent;
	assign g_abs = lvl_g < thr.absent;
	assign b_abs = lvl_b < thr.absent;
	assign r_mix = lvl_r >= thr.mixed;
	assign g_mix = lvl_g >= thr.mixed;

	// rules in priority order, first match wins
	always_comb begin
		r_n   = lvl_r;
		g_n   = lvl_g;
		b_n   = lvl_b;
		cls_n = CLS_NONE;
		if (r_dom && g_abs && b_abs) begin
			r_n = FULL_LEVEL; g_n = ZERO_LEVEL; b_n = ZERO_LEVEL; cls_n = CLS_RED;
		end else if (g_dom && r_abs && b_abs) begin
			r_n = ZERO_LEVEL; g_n = FULL_LEVEL; b_n = ZERO_LEVEL; cls_n = CLS_GREEN;
		end else if (b_dom && r_abs && g_abs) begin
			r_n = ZERO_LEVEL; g_n = ZERO_LEVEL; b_n = FULL_LEVEL; cls_n = CLS_BLUE;
		end else if (r_mix && g_mix && b_abs) begin
			r_n = FULL_LEVEL; g_n = FULL_LEVEL; b_n = ZERO_LEVEL; cls_n = CLS_YELLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q   <= r_n;
			g_q   <= g_n;
			b_q   <= b_n;
			cls_q <= cls_n;
		end
	end

	assign out_valid   = vld_q;
	assign out_red     = r_q;
	assign out_green   = g_q;
	assign out_blue    = b_q;
	assign color_class = cls_q;

endmodule

// ===== design/rgbc_color_normalize_classify.sv =====
// top level of the rgbc colour normaliser and classifier
// depends on rgbc_pkg, rgbc_regs, rgbc_div_lane and rgbc_classify
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_ready  | raw_red, raw_green, raw_blue, raw_clear
//  result  | out_valid/out_ready| out_red, out_green, out_blue, color_class
//  config  | apb, pready high   | paddr, pwdata, prdata (thresholds)
//
//  one item per cycle unless the output stalls; stages: two 9-stage divider lane banks
//  (one quotient bit per stage), one peak stage and the output register
//  a zero clear count or an all-zero level item drops out with no result
//  the whole pipeline holds while a result waits and out_ready is low
//  reset clears every stage valid bit and loads the threshold reset values
module rgbc_color_normalize_classify (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rgbc_pkg::RAW_W-1:0]   raw_red,
	input  logic [rgbc_pkg::RAW_W-1:0]   raw_green,
	input  logic [rgbc_pkg::RAW_W-1:0]   raw_blue,
	input  logic [rgbc_pkg::RAW_W-1:0]   raw_clear,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_red,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_green,
	output logic [rgbc_pkg::LEVEL_W-1:0] out_blue,
	output logic [rgbc_pkg::CLASS_W-1:0] color_class,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rgbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [rgbc_pkg::DATA_W-1:0]  pwdata,
	output logic [rgbc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import rgbc_pkg::*;

	thr_t               thr;
	logic               en;
	logic [RAW_W-1:0]   raw_m [0:LANES-1];
	logic [RAW_W-1:0]   clear_m;
	logic [LEVEL_W-1:0] lvl_a [0:LANES-1];
	logic [LEVEL_W-1:0] lvl_b [0:LANES-1];
	logic               vld_a_q [0:STEPS];
	logic               vld_b_q [0:STEPS];
	logic [LEVEL_W-1:0] lvl_s10 [0:LANES-1];
	logic [LEVEL_W-1:0] peak_s10;
	logic               vld_s10_q;
	logic [LEVEL_W-1:0] peak_n;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign raw_m[0] = raw_red   & SAMPLE_MASK;
	assign raw_m[1] = raw_green & SAMPLE_MASK;
	assign raw_m[2] = raw_blue  & SAMPLE_MASK;
	assign clear_m  = raw_clear & SAMPLE_MASK;

	rgbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	// first bank: level = min(raw * 255 / clear, 255)
	for (genvar i = 0; i < LANES; i++) begin : g_lane_a
		rgbc_div_lane u_div (
			.clk (clk),
			.en  (en),
			.num ({raw_m[i], ZERO_LEVEL} - {ZERO_LEVEL, raw_m[i]}),
			.den (clear_m),
			.quo (lvl_a[i])
		);
	end

	always_comb begin
		peak_n = lvl_a[0];
		if (lvl_a[1] > peak_n) begin
			peak_n = lvl_a[1];
		end
		if (lvl_a[2] > peak_n) begin
			peak_n = lvl_a[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s10  <= lvl_a;
			peak_s10 <= peak_n;
		end
	end

	// second bank: stretch so the peak reaches full level
	for (genvar i = 0; i < LANES; i++) begin : g_lane_b
		rgbc_div_lane u_div (
			.clk (clk),
			.en  (en),
			.num (NUM_W'({lvl_s10[i], ZERO_LEVEL} - {ZERO_LEVEL, lvl_s10[i]})),
			.den (DEN_W'(peak_s10)),
			.quo (lvl_b[i])
		);
	end

	// item valid bits travel alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				vld_a_q[k] <= 1'b0;
				vld_b_q[k] <= 1'b0;
			end
			vld_s10_q <= 1'b0;
		end else if (en) begin
			vld_a_q[0] <= in_valid && (clear_m != '0);
			for (int k = 1; k <= STEPS; k++) begin
				vld_a_q[k] <= vld_a_q[k-1];
				vld_b_q[k] <= vld_b_q[k-1];
			end
			vld_s10_q  <= vld_a_q[STEPS] && (peak_n != '0);
			vld_b_q[0] <= vld_s10_q;
		end
	end

	rgbc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (vld_b_q[STEPS]),
		.lvl_r       (lvl_b[0]),
		.lvl_g       (lvl_b[1]),
		.lvl_b       (lvl_b[2]),
		.thr         (thr),
		.out_valid   (out_valid),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.color_class (color_class)
	);

	// a peak that survives the zero check is never zero
	a_peak_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10_q |-> peak_s10 != '0)
		else $error("zero peak reached the stretch lanes");

	// an unclassified colour is stretched, so one channel sits at full level
	a_stretch_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && color_class == CLS_NONE |->
		out_red == FULL_LEVEL || out_green == FULL_LEVEL || out_blue == FULL_LEVEL)
		else $error("stretched colour has no channel at full level");

	// pure red is forced to full-intensity red
	a_red_forced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && color_class == CLS_RED |->
		out_red == FULL_LEVEL && out_green == ZERO_LEVEL && out_blue == ZERO_LEVEL)
		else $error("red item not forced");

	// stalled pipeline keeps its items in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s10_q) && $stable(vld_b_q[STEPS]))
		else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/tb_rgbc_color_normalize_classify.sv =====
// self-checking testbench for the rgbc colour normaliser and classifier
// needs rgbc_pkg and the rgbc_color_normalize_classify rtl; predicts every result in-line
// and checks results in order, with random idling on both sides and apb threshold updates
module tb_rgbc_color_normalize_classify;
	import rgbc_pkg::*;

	localparam int          PIPE_LATENCY  = 20;
	localparam int          DRAIN_LIMIT   = 5000;
	localparam int unsigned FULL          = 32'(FULL_LEVEL);
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [CLASS_W-1:0] cls;
	} colour_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [RAW_W-1:0]    raw_red;
	logic [RAW_W-1:0]    raw_green;
	logic [RAW_W-1:0]    raw_blue;
	logic [RAW_W-1:0]    raw_clear;
	logic                out_valid;
	logic                out_ready;
	logic [LEVEL_W-1:0]  out_red;
	logic [LEVEL_W-1:0]  out_green;
	logic [LEVEL_W-1:0]  out_blue;
	logic [CLASS_W-1:0]  color_class;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	thr_t     thresholds;
	colour_t  expected_colours[$];
	int       fault_count = 0;
	int       source_gap_odds = 20;
	int       sink_stall_odds = 20;

	rgbc_color_normalize_classify i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_red     (raw_red),
		.raw_green   (raw_green),
		.raw_blue    (raw_blue),
		.raw_clear   (raw_clear),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.color_class (color_class),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	function automatic int unsigned channel_level(input int unsigned raw, input int unsigned clr);
		int unsigned q;
		q = (raw * FULL) / clr;
		return (q > FULL) ? FULL : q;
	endfunction

	// returns 0 when the sample is dropped without a result
	function automatic bit predict_colour(input logic [RAW_W-1:0] r_raw, g_raw, b_raw, c_raw,
			output colour_t res);
		int unsigned clr, r, g, b, peak;
		res = '0;
		clr = 32'(c_raw & SAMPLE_MASK);
		if (clr == 0) begin
			return 1'b0;
		end
		r = channel_level(32'(r_raw & SAMPLE_MASK), clr);
		g = channel_level(32'(g_raw & SAMPLE_MASK), clr);
		b = channel_level(32'(b_raw & SAMPLE_MASK), clr);
		peak = r;
		if (g > peak) peak = g;
		if (b > peak) peak = b;
		if (peak == 0) begin
			return 1'b0;
		end
		r = (r * FULL) / peak;
		g = (g * FULL) / peak;
		b = (b * FULL) / peak;
		if (r >= thresholds.dominant && g < thresholds.absent && b < thresholds.absent) begin
			res = '{FULL_LEVEL, ZERO_LEVEL, ZERO_LEVEL, CLS_RED};
		end else if (g >= thresholds.dominant && r < thresholds.absent
				&& b < thresholds.absent) begin
			res = '{ZERO_LEVEL, FULL_LEVEL, ZERO_LEVEL, CLS_GREEN};
		end else if (b >= thresholds.dominant && r < thresholds.absent
				&& g < thresholds.absent) begin
			res = '{ZERO_LEVEL, ZERO_LEVEL, FULL_LEVEL, CLS_BLUE};
		end else if (r >= thresholds.mixed && g >= thresholds.mixed
				&& b < thresholds.absent) begin
			res = '{FULL_LEVEL, FULL_LEVEL, ZERO_LEVEL, CLS_YELLOW};
		end else begin
			res = '{r[LEVEL_W-1:0], g[LEVEL_W-1:0], b[LEVEL_W-1:0], CLS_NONE};
		end
		return 1'b1;
	endfunction

	// result sink pacing: random stall bursts, none while the odds are zero
	initial begin : sink_pacing
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_stall_odds != 0 && $urandom_range(1, 100) <= sink_stall_odds) begin
				stall_left = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		colour_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{out_red, out_green, out_blue, color_class};
			if (expected_colours.size() == 0) begin
				note_fault($sformatf("unexpected result r=%0d g=%0d b=%0d class=%0d",
					got.red, got.green, got.blue, got.cls));
			end else begin
				want = expected_colours.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.cls !== want.cls) begin
					note_fault($sformatf({"mismatch: expected r=%0d g=%0d b=%0d class=%0d, ",
						"got r=%0d g=%0d b=%0d class=%0d"},
						want.red, want.green, want.blue, want.cls,
						got.red, got.green, got.blue, got.cls));
				end
			end
		end
	end

	task automatic send_sample(input logic [RAW_W-1:0] r, g, b, c);
		colour_t want;
		int gap;
		if (source_gap_odds != 0 && $urandom_range(1, 100) <= source_gap_odds) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		raw_red   <= r;
		raw_green <= g;
		raw_blue  <= b;
		raw_clear <= c;
		do @(posedge clk); while (!in_ready);
		if (predict_colour(r, g, b, c, want)) begin
			expected_colours.push_back(want);
		end
	endtask

	function automatic logic [RAW_W-1:0] fraction_of_clear(input int unsigned clr,
			input int unsigned lo, input int unsigned hi);
		int unsigned v;
		v = (clr * $urandom_range(lo, hi)) / 256;
		return (v > 65535) ? 16'hFFFF : v[RAW_W-1:0];
	endfunction

	// mostly coloured samples built around the clear count, plus raw noise and dropped items
	task automatic send_random_sample();
		int unsigned clr, kind, lead;
		logic [RAW_W-1:0] ch [3];
		kind = $urandom_range(0, 99);
		clr  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
		if (kind < 20) begin
			lead = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) begin
				ch[k] = (k == lead) ? fraction_of_clear(clr, 100, 320)
				                    : fraction_of_clear(clr, 0, 70);
			end
		end else if (kind < 35) begin
			ch[0] = fraction_of_clear(clr, 120, 320);
			ch[1] = fraction_of_clear(clr, 120, 320);
			ch[2] = fraction_of_clear(clr, 0, 60);
		end else if (kind < 70) begin
			for (int k = 0; k < 3; k++) ch[k] = fraction_of_clear(clr, 0, 300);
		end else if (kind < 90) begin
			for (int k = 0; k < 3; k++) ch[k] = RAW_W'($urandom_range(0, 65535));
			clr = $urandom_range(0, 65535);
		end else if (kind < 95) begin
			for (int k = 0; k < 3; k++) ch[k] = RAW_W'($urandom_range(0, 65535));
			clr = 0;
		end else begin
			// tiny channels against the clear count, levels mostly round down to zero
			for (int k = 0; k < 3; k++) ch[k] = RAW_W'($urandom_range(0, clr / 200));
		end
		send_sample(ch[0], ch[1], ch[2], clr[RAW_W-1:0]);
	endtask

	task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			case (addr[3:2])
				REG_DOMINANT: thresholds.dominant = wdata[LEVEL_W-1:0];
				REG_ABSENT:   thresholds.absent   = wdata[LEVEL_W-1:0];
				REG_MIXED:    thresholds.mixed    = wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [LEVEL_W-1:0] want);
		logic [DATA_W-1:0] rdata;
		apb_transfer(1'b0, {idx, 2'b00}, '0, rdata);
		if (rdata !== {{(DATA_W-LEVEL_W){1'b0}}, want}) begin
			note_fault($sformatf("register %0d read: expected %0d, got %0h", idx, want, rdata));
		end
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && expected_colours.size() != 0; i++) @(posedge clk);
		// dropped items can still be in flight after the last result
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (expected_colours.size() != 0) begin
			note_fault($sformatf("%0d results never arrived", expected_colours.size()));
			expected_colours.delete();
		end
	endtask

	// upper data bits are random so that truncation to 8 bits is exercised
	task automatic set_thresholds(input logic [LEVEL_W-1:0] dom, absent, mixed);
		logic [DATA_W-1:0] rdata;
		drain_pipeline();
		apb_transfer(1'b1, {REG_DOMINANT, 2'b00},
			{24'($urandom_range(0, 32'hFFFFFF)), dom}, rdata);
		apb_transfer(1'b1, {REG_ABSENT, 2'b00},
			{24'($urandom_range(0, 32'hFFFFFF)), absent}, rdata);
		apb_transfer(1'b1, {REG_MIXED, 2'b00},
			{24'($urandom_range(0, 32'hFFFFFF)), mixed}, rdata);
		apb_transfer(1'b1, ADDR_UNMAPPED, $urandom, rdata);
		check_register(REG_DOMINANT, thresholds.dominant);
		check_register(REG_ABSENT, thresholds.absent);
		check_register(REG_MIXED, thresholds.mixed);
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: source_gap_odds = 0;
			1: source_gap_odds = 10;
			2: source_gap_odds = 30;
			default: source_gap_odds = 60;
		endcase
		case ($urandom_range(0, 3))
			0: sink_stall_odds = 0;
			1: sink_stall_odds = 10;
			2: sink_stall_odds = 30;
			default: sink_stall_odds = 60;
		endcase
	endtask

	task automatic test_register_reset_values();
		check_register(REG_DOMINANT, DOMINANT_RST);
		check_register(REG_ABSENT, ABSENT_RST);
		check_register(REG_MIXED, MIXED_RST);
	endtask

	// runs at reset thresholds: dominant 200, absent 80, mixed 150
	task automatic test_directed_samples();
		send_sample(16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		send_sample(16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_sample(16'd100, 16'd100, 16'd0, 16'hFFFF);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'd1, 16'd0, 16'd0, 16'd1);
		send_sample(16'd0, 16'hFFFF, 16'd0, 16'd1);
		send_sample(16'd0, 16'd0, 16'd300, 16'd300);
		send_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		send_sample(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		send_sample(16'd258, 16'd0, 16'd0, 16'hFFFF);
		send_sample(16'd1000, 16'd1000, 16'd10, 16'd1000);
		send_sample(16'd1000, 16'd900, 16'd200, 16'd1000);
		send_sample(16'd128, 16'd128, 16'd128, 16'd256);
		// absent and mixed boundaries with clear 255, where level equals the raw count
		send_sample(16'd255, 16'd79, 16'd0, 16'd255);
		send_sample(16'd255, 16'd80, 16'd0, 16'd255);
		send_sample(16'd255, 16'd150, 16'd79, 16'd255);
		send_sample(16'd255, 16'd150, 16'd80, 16'd255);
		send_sample(16'd255, 16'd149, 16'd0, 16'd255);
		send_sample(16'hAAAA, 16'h5555, 16'hFFFF, 16'h8000);
		send_sample(16'h5555, 16'hAAAA, 16'h0000, 16'h7FFF);
	endtask

	task automatic test_threshold_extremes();
		source_gap_odds = 25;
		sink_stall_odds = 25;
		set_thresholds(8'd0, 8'd0, 8'd0);
		repeat (60) send_random_sample();
		set_thresholds(8'd255, 8'd255, 8'd255);
		repeat (60) send_random_sample();
		set_thresholds(8'd0, 8'd255, 8'd0);
		repeat (60) send_random_sample();
		set_thresholds(8'd255, 8'd0, 8'd255);
		repeat (60) send_random_sample();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			if (phase % 2 == 0) begin
				set_thresholds(LEVEL_W'($urandom_range(150, 255)),
					LEVEL_W'($urandom_range(30, 120)), LEVEL_W'($urandom_range(100, 220)));
			end else begin
				set_thresholds(LEVEL_W'($urandom_range(0, 255)),
					LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
			end
			pick_idling();
			repeat (180) send_random_sample();
		end
	endtask

	// back-to-back items with the sink always ready
	task automatic test_steady_stream();
		set_thresholds(DOMINANT_RST, ABSENT_RST, MIXED_RST);
		source_gap_odds = 0;
		sink_stall_odds = 0;
		repeat (200) send_random_sample();
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		raw_red   <= '0;
		raw_green <= '0;
		raw_blue  <= '0;
		raw_clear <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		thresholds = '{DOMINANT_RST, ABSENT_RST, MIXED_RST};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset_values();
		test_directed_samples();
		test_threshold_extremes();
		test_random_traffic();
		test_steady_stream();
		drain_pipeline();
		if (fault_count == 0) begin
			$display("rgbc_color_normalize_classify verification clean");
		end else begin
			$display("rgbc_color_normalize_classify verification failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("rgbc_color_normalize_classify verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rgbc_pkg.sv
design/rgbc_regs.sv
design/rgbc_div_lane.sv
design/rgbc_classify.sv
design/rgbc_color_normalize_classify.sv
tb/sv/tb_rgbc_color_normalize_classify.sv
